FILE: rtl/core/btc_pkg.sv
// Shared types, register codes and pixel classification for the tricolor row packer.
package btc_pkg;

  localparam int DEPTH_W     = 3;
  localparam int VIS_W       = 12;
  localparam int ROWB_W      = 14;
  localparam int ROWCNT_W    = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int LOW_ENTRIES = 16;

  localparam int DEF_MAX_ROW_PIXELS  = 2048;
  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam logic [7:0] WHITE_LEVEL     = 8'h80;
  localparam logic [9:0] WHITE_SUM_LEVEL = 10'h180;
  localparam logic [7:0] COLOR_LEVEL     = 8'hF0;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEPTH_SELECT  = 3'd0,
    CFG_FORMAT_565    = 3'd1,
    CFG_COLOR_ENABLE  = 3'd2,
    CFG_VISIBLE_WIDTH = 3'd3,
    CFG_ROW_BYTES     = 3'd4
  } cfg_reg_t;

  // Pixel depth codes; the unused code behaves as 32 bit
  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_1  = 3'd0,
    DEPTH_2  = 3'd1,
    DEPTH_4  = 3'd2,
    DEPTH_8  = 3'd3,
    DEPTH_16 = 3'd4,
    DEPTH_24 = 3'd5,
    DEPTH_32 = 3'd6
  } depth_t;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_t;

  localparam logic [DEPTH_W-1:0] RST_DEPTH_SELECT  = DEPTH_24;
  localparam logic               RST_FORMAT_565    = 1'b0;
  localparam logic               RST_COLOR_ENABLE  = 1'b1;
  localparam logic [VIS_W-1:0]   RST_VISIBLE_WIDTH = 12'd800;
  localparam logic [ROWB_W-1:0]  RST_ROW_BYTES     = 14'd2400;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_select;
    logic               format_565;
    logic               color_enable;
    logic [VIS_W-1:0]   visible_width;
    logic [ROWB_W-1:0]  row_bytes;
  } cfg_t;

  typedef struct packed {
    logic white;
    logic colored;
  } pal_class_t;

  // Up to eight pixels of one data byte, pixel 0 first
  typedef struct packed {
    logic [3:0] count;
    logic [7:0] white;
    logic [7:0] colored;
  } pix_t;

  function automatic logic plane_on(input cfg_t cfg);
    return cfg.color_enable && (cfg.depth_select != DEPTH_1);
  endfunction

  function automatic pal_class_t classify(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic plane);
    logic [9:0] sum;
    pal_class_t cls;
    sum = 10'(r) + 10'(g) + 10'(b);
    cls.white = plane ? ((r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL))
                      : (sum > WHITE_SUM_LEVEL);
    cls.colored = (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
    return cls;
  endfunction

endpackage

FILE: rtl/core/bmp_to_tricolor_row_packer_core.sv
// Top level of the bitmap to tricolor row packer: config registers, palette RAM, pipeline.
//
//  channel   handshake                   payload
//  --------  --------------------------  -----------------------------------------------
//  item      item_valid / item_stall     command, palette_index, red, green, blue,
//                                        data_byte
//  result    result_valid / result_stall mono_byte, color_byte, byte_position, row_last
//  cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//
// Flow: one item per cycle while item_stall is low. A transferred item is classified
//   and written to, or looked up in, the palette RAM at its transfer edge; the first stage
//   then holds it, and its result, if any, is registered in the output register when the
//   first stage fires. The palette RAM read data is registered alongside the first stage.
// Reset: rst clears the counters, accumulators, gather and valid flags. The palette RAM
//   has no reset and no clearing pass; load palette entries before they are used.
// Stalls: item_stall is high only while the first stage holds an item and the output
//   register holds a result that is stalled; cfg_ready is always high.
module bmp_to_tricolor_row_packer_core #(
  parameter int MAX_ROW_PIXELS  = btc_pkg::DEF_MAX_ROW_PIXELS,
  parameter int PALETTE_ENTRIES = btc_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           command,
  input  logic [7:0]                     palette_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [7:0]                     data_byte,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [7:0]                     mono_byte,
  output logic [7:0]                     color_byte,
  output logic [7:0]                     byte_position,
  output logic                           row_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [btc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import btc_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  cfg_t       cfg;
  logic       item_take;
  logic       s1_valid;
  logic       s1_command;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       pix_fire;
  logic       row_end;
  logic       pal_we;
  logic       pal_re;
  pal_class_t pal_class;
  pal_class_t ram_class;
  pix_t       pix;

  // Configuration registers; a write is taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_select  <= RST_DEPTH_SELECT;
      cfg.format_565    <= RST_FORMAT_565;
      cfg.color_enable  <= RST_COLOR_ENABLE;
      cfg.visible_width <= RST_VISIBLE_WIDTH;
      cfg.row_bytes     <= RST_ROW_BYTES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEPTH_SELECT:  cfg.depth_select  <= cfg_data[DEPTH_W-1:0];
        CFG_FORMAT_565:    cfg.format_565    <= cfg_data[0];
        CFG_COLOR_ENABLE:  cfg.color_enable  <= cfg_data[0];
        CFG_VISIBLE_WIDTH: cfg.visible_width <= cfg_data[VIS_W-1:0];
        CFG_ROW_BYTES:     cfg.row_bytes     <= cfg_data[ROWB_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the first stage only while a finished result is stalled at the output
  assign s1_fire    = s1_valid && !(result_valid && result_stall);
  assign pix_fire   = s1_fire && (s1_command == CMD_PIXEL);
  assign item_stall = s1_valid && result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_command <= command;
      s1_byte    <= data_byte;
    end
  end

  // Classify palette entries on transfer; loads beyond the table are dropped
  assign pal_class = classify(red, green, blue, plane_on(cfg));
  assign pal_we    = item_take && (command == CMD_PALETTE)
                     && (32'(palette_index) < 32'(PALETTE_ENTRIES));
  assign pal_re    = item_take && (command == CMD_PIXEL);

  btc_ram #(
    .WIDTH($bits(pal_class_t)),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(palette_index[PAL_AW-1:0]),
    .wdata(pal_class),
    .re   (pal_re),
    .raddr(data_byte[PAL_AW-1:0]),
    .rdata(ram_class)
  );

  btc_pixel_decode #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (pix_fire),
    .row_end  (row_end),
    .data     (s1_byte),
    .ram_class(ram_class),
    .pal_we   (pal_we),
    .pal_index(palette_index),
    .pal_class(pal_class),
    .pix      (pix)
  );

  btc_row_pack #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_pack (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (pix_fire),
    .pix          (pix),
    .row_end      (row_end),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .mono_byte    (mono_byte),
    .color_byte   (color_byte),
    .byte_position(byte_position),
    .row_last     (row_last)
  );

  // Input stalls only behind an occupied first stage
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("item stalled with an empty first stage");

  // A held first stage keeps its item
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> s1_valid)
    else $error("first stage lost a held item");

  // A new result comes only from a pixel byte leaving the first stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pix_fire))
    else $error("result appeared without a pixel transfer");

  // A palette load never reads the RAM and a pixel byte never writes it
  a_ram_port_use: assert property (@(posedge clk) disable iff (rst)
    !(pal_we && pal_re))
    else $error("palette RAM read and written by one transfer");

endmodule

FILE: rtl/core/btc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/btc_pixel_decode.sv
// Pixel unpacking: palette lookup, multi-byte gather and color decode of one data byte.
module btc_pixel_decode #(
  parameter int PALETTE_ENTRIES = btc_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  btc_pkg::cfg_t       cfg,
  input  logic                fire,
  input  logic                row_end,
  input  logic [7:0]          data,
  input  btc_pkg::pal_class_t ram_class,
  input  logic                pal_we,
  input  logic [7:0]          pal_index,
  input  btc_pkg::pal_class_t pal_class,
  output btc_pkg::pix_t       pix
);
  import btc_pkg::*;

  logic [LOW_ENTRIES-1:0] low_white;
  logic [LOW_ENTRIES-1:0] low_color;
  logic [23:0]            gather;
  logic [1:0]             gather_count;
  logic [23:0]            gather_next;
  logic [2:0]             need;
  logic                   complete;
  logic                   is_gather;
  logic [7:0]             r;
  logic [7:0]             g;
  logic [7:0]             b;
  pal_class_t             rgb_class;

  // Low palette entries kept in flops for the multi-pixel depths
  always_ff @(posedge clk) begin
    if (pal_we && (pal_index < 8'(LOW_ENTRIES))) begin
      low_white[pal_index[3:0]] <= pal_class.white;
      low_color[pal_index[3:0]] <= pal_class.colored;
    end
  end

  assign is_gather = !(cfg.depth_select inside {DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8});

  always_comb begin
    case (gather_count)
      2'd0:    gather_next = gather | {16'd0, data};
      2'd1:    gather_next = gather | {8'd0, data, 8'd0};
      2'd2:    gather_next = gather | {data, 16'd0};
      default: gather_next = gather;
    endcase
    case (cfg.depth_select)
      DEPTH_16: need = 3'd2;
      DEPTH_24: need = 3'd3;
      default:  need = 3'd4;
    endcase
    complete = ({1'b0, gather_count} + 3'd1) >= need;
    if (cfg.depth_select == DEPTH_16) begin
      b = {gather_next[4:0], 3'd0};
      if (cfg.format_565) begin
        g = {gather_next[10:8], gather_next[7:5], 2'd0};
        r = {gather_next[15:11], 3'd0};
      end else begin
        g = {gather_next[9:8], gather_next[7:5], 3'd0};
        r = {gather_next[14:10], 3'd0};
      end
    end else begin
      r = gather_next[23:16];
      g = gather_next[15:8];
      b = gather_next[7:0];
    end
    rgb_class = classify(r, g, b, plane_on(cfg));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather       <= '0;
      gather_count <= '0;
    end else if (fire) begin
      if (row_end || (is_gather && complete)) begin
        gather       <= '0;
        gather_count <= '0;
      end else if (is_gather) begin
        gather       <= gather_next;
        gather_count <= gather_count + 2'd1;
      end
    end
  end

  always_comb begin
    logic [3:0] pn;
    pix = '0;
    pn  = '0;
    case (cfg.depth_select)
      DEPTH_1: begin
        pix.count = 4'd8;
        for (int i = 0; i < 8; i++) begin
          pn = {3'd0, data[7-i]};
          if (32'(pn) < 32'(PALETTE_ENTRIES)) begin
            pix.white[i]   = low_white[pn];
            pix.colored[i] = low_color[pn];
          end
        end
      end
      DEPTH_2: begin
        pix.count = 4'd4;
        for (int i = 0; i < 4; i++) begin
          pn = {2'd0, data[7-2*i -: 2]};
          if (32'(pn) < 32'(PALETTE_ENTRIES)) begin
            pix.white[i]   = low_white[pn];
            pix.colored[i] = low_color[pn];
          end
        end
      end
      DEPTH_4: begin
        pix.count = 4'd2;
        for (int i = 0; i < 2; i++) begin
          pn = data[7-4*i -: 4];
          if (32'(pn) < 32'(PALETTE_ENTRIES)) begin
            pix.white[i]   = low_white[pn];
            pix.colored[i] = low_color[pn];
          end
        end
      end
      DEPTH_8: begin
        pix.count = 4'd1;
        if (32'(data) < 32'(PALETTE_ENTRIES)) begin
          pix.white[0]   = ram_class.white;
          pix.colored[0] = ram_class.colored;
        end
      end
      default: begin
        pix.count      = complete ? 4'd1 : 4'd0;
        pix.white[0]   = rgb_class.white;
        pix.colored[0] = rgb_class.colored;
      end
    endcase
    // Colored pixels count only while the color plane is on
    pix.colored = pix.colored & {8{plane_on(cfg)}};
  end

endmodule

FILE: rtl/core/btc_row_pack.sv
// Row packing: column tracking, bit accumulation, row end handling and the output register.
module btc_row_pack #(
  parameter int MAX_ROW_PIXELS = btc_pkg::DEF_MAX_ROW_PIXELS,
  localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  btc_pkg::cfg_t cfg,
  input  logic          fire,
  input  btc_pkg::pix_t pix,
  output logic          row_end,
  input  logic          result_stall,
  output logic          result_valid,
  output logic [7:0]    mono_byte,
  output logic [7:0]    color_byte,
  output logic [7:0]    byte_position,
  output logic          row_last
);
  import btc_pkg::*;

  logic [CW-1:0]       column;
  logic [7:0]          mono_accum;
  logic [7:0]          color_accum;
  logic [7:0]          out_position;
  logic [ROWCNT_W-1:0] row_byte_count;

  logic [CW-1:0]       vw;
  logic [CW-1:0]       column_next;
  logic [7:0]          mono_next;
  logic [7:0]          color_next;
  logic [7:0]          position_next;
  logic                emit;
  logic [7:0]          emit_mono;
  logic [7:0]          emit_color;
  logic [7:0]          emit_position;
  logic                emit_last;

  assign vw = (32'(cfg.visible_width) > 32'(MAX_ROW_PIXELS)) ? CW'(MAX_ROW_PIXELS)
                                                             : CW'(cfg.visible_width);
  assign row_end = ({1'b0, row_byte_count} + 14'd1) >= cfg.row_bytes;

  always_comb begin
    logic [CW:0] col;
    logic        in_row;
    logic        at_end;
    logic [2:0]  bit_idx;
    col           = '0;
    in_row        = 1'b0;
    at_end        = 1'b0;
    bit_idx       = '0;
    mono_next     = mono_accum;
    color_next    = color_accum;
    position_next = out_position;
    column_next   = column;
    emit          = 1'b0;
    emit_mono     = 8'hFF;
    emit_color    = 8'hFF;
    emit_position = '0;
    emit_last     = 1'b0;
    for (int i = 0; i < 8; i++) begin
      col    = {1'b0, column} + (CW+1)'(i);
      in_row = (4'(i) < pix.count) && (col < {1'b0, vw});
      at_end = (col + (CW+1)'(1)) == {1'b0, vw};
      if (in_row) begin
        bit_idx = 3'd7 - col[2:0];
        if (!pix.white[i]) begin
          if (pix.colored[i]) begin
            color_next[bit_idx] = 1'b0;
          end else begin
            mono_next[bit_idx] = 1'b0;
          end
        end
        column_next = column_next + CW'(1);
        // Byte full or last visible pixel: emit; a later emit in the same step wins
        if ((col[2:0] == 3'd7) || at_end) begin
          emit          = 1'b1;
          emit_mono     = mono_next;
          emit_color    = color_next;
          emit_position = position_next;
          emit_last     = at_end;
          position_next = position_next + 8'd1;
          mono_next     = 8'hFF;
          color_next    = 8'hFF;
        end
      end
    end
    // Short row: mark the emitted byte last, or flush the partial byte
    if (row_end && (column_next < vw)) begin
      if (emit) begin
        emit_last = 1'b1;
      end else if (column_next[2:0] != 3'd0) begin
        emit          = 1'b1;
        emit_mono     = mono_next;
        emit_color    = color_next;
        emit_position = position_next;
        emit_last     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      mono_accum     <= 8'hFF;
      color_accum    <= 8'hFF;
      out_position   <= '0;
      row_byte_count <= '0;
    end else if (fire) begin
      if (row_end) begin
        column         <= '0;
        mono_accum     <= 8'hFF;
        color_accum    <= 8'hFF;
        out_position   <= '0;
        row_byte_count <= '0;
      end else begin
        column         <= column_next;
        mono_accum     <= mono_next;
        color_accum    <= color_next;
        out_position   <= position_next;
        row_byte_count <= row_byte_count + ROWCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      mono_byte     <= emit_mono;
      color_byte    <= emit_color;
      byte_position <= emit_position;
      row_last      <= emit_last;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bitmap to tricolor row packer core.
`timescale 1ns / 100ps

module testbench;
  import btc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int MAX_W         = DEF_MAX_ROW_PIXELS;
  localparam int PAL_N         = DEF_PALETTE_ENTRIES;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 70;
  localparam int QUIET_ITEMS   = 30;
  // The slowest correct run is about two hundred microseconds; allow ten times that.
  localparam int RUN_LIMIT_NS  = 2_000_000;
  // Depth code with no enum member; the block treats it as 32 bit.
  localparam logic [DEPTH_W-1:0] DEPTH_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] mono;
    logic [7:0] color;
    logic [7:0] pos;
    logic       last;
  } out_byte_t;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic                   command;
  logic [7:0]             palette_index;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic [7:0]             data_byte;
  logic                   result_valid;
  logic                   result_stall;
  logic [7:0]             mono_byte;
  logic [7:0]             color_byte;
  logic [7:0]             byte_position;
  logic                   row_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shared controls between the sender and the receiver processes
  bit quiet    = 1'b0;  // set for the last part of the run: no idling on either side
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  int fail_count = 0;

  bmp_to_tricolor_row_packer_core dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor state: palette classes, configuration, row counters, accumulators
  // ---------------------------------------------------------------------------
  logic              pal_white [PAL_N];
  logic              pal_color [PAL_N];
  logic [23:0]       gather_word;
  int                gather_n;
  int                row_pos;
  int                col;
  logic [7:0]        mono_acc;
  logic [7:0]        color_acc;
  logic [7:0]        out_pos;
  logic [DEPTH_W-1:0] cur_depth;
  logic              cur_565;
  logic              cur_color;
  logic [VIS_W-1:0]  cur_width;
  logic [ROWB_W-1:0] cur_row_bytes;
  logic              emit_now;
  out_byte_t         emit_rec;
  out_byte_t         expected_bytes [$];
  out_byte_t         want;

  // The color plane never exists for 1-bit pictures.
  function automatic logic plane_active();
    return cur_color && (cur_depth != DEPTH_1);
  endfunction

  function automatic logic is_light(input int r, input int g, input int b);
    if (plane_active())
      return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    return (r + g + b) > 3 * WHITE_LEVEL;
  endfunction

  function automatic logic is_tinted(input int r, input int g, input int b);
    return (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
  endfunction

  function automatic int width_cap();
    return (cur_width > MAX_W) ? MAX_W : int'(cur_width);
  endfunction

  function automatic int pixel_bits(input logic [DEPTH_W-1:0] d);
    case (d)
      DEPTH_1:  return 1;
      DEPTH_2:  return 2;
      DEPTH_4:  return 4;
      DEPTH_8:  return 8;
      DEPTH_16: return 16;
      DEPTH_24: return 24;
      default:  return 32;
    endcase
  endfunction

  function automatic void clear_row();
    gather_word = '0;
    gather_n    = 0;
    row_pos     = 0;
    col         = 0;
    mono_acc    = 8'hFF;
    color_acc   = 8'hFF;
    out_pos     = '0;
  endfunction

  // A later flush in the same item replaces an earlier one: one result per item.
  function automatic void flush_byte(input logic last);
    emit_now  = 1'b1;
    emit_rec  = '{mono: mono_acc, color: color_acc, pos: out_pos, last: last};
    out_pos   = out_pos + 8'd1;
    mono_acc  = 8'hFF;
    color_acc = 8'hFF;
  endfunction

  function automatic void place_pixel(input logic white, input logic tinted);
    int         lim;
    logic [7:0] bit_mask;
    lim = width_cap();
    if (col >= lim) return;
    bit_mask = 8'h80 >> (col % 8);
    if (!white) begin
      if (tinted && plane_active()) color_acc &= ~bit_mask;
      else mono_acc &= ~bit_mask;
    end
    if ((col % 8) == 7 || col == lim - 1) flush_byte(col == lim - 1);
    col++;
  endfunction

  // Turn the little-endian gather into one RGB pixel.
  function automatic void decode_gathered();
    int lo, hi, r, g, b;
    lo = gather_word[7:0];
    hi = gather_word[15:8];
    if (cur_depth == DEPTH_16) begin
      b = (lo & 'h1F) << 3;
      if (!cur_565) begin
        g = ((hi & 'h03) << 6) | ((lo & 'hE0) >> 2);
        r = (hi & 'h7C) << 1;
      end else begin
        g = ((hi & 'h07) << 5) | ((lo & 'hE0) >> 3);
        r = hi & 'hF8;
      end
      g &= 'hFF;
    end else begin
      r = gather_word[23:16];
      g = hi;
      b = lo;
    end
    place_pixel(is_light(r, g, b), is_tinted(r, g, b));
  endfunction

  // Advance the predictor by one transferred item; queue the byte it yields.
  function automatic void predict_item(input cmd_t cmd, input logic [7:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [7:0] data);
    int nbits, npix, need, pn, i;
    emit_now = 1'b0;
    if (cmd == CMD_PALETTE) begin
      pal_white[idx] = is_light(r, g, b);
      pal_color[idx] = is_tinted(r, g, b);
      return;
    end
    if (cur_depth <= DEPTH_8) begin
      // Palette pixels, MSB first within the byte
      nbits = pixel_bits(cur_depth);
      npix  = 8 / nbits;
      for (i = 0; i < npix; i++) begin
        pn = (data >> (8 - nbits * (i + 1))) & ((1 << nbits) - 1);
        place_pixel(pal_white[pn], pal_color[pn]);
      end
    end else begin
      need = pixel_bits(cur_depth) / 8;
      if (gather_n < 3) gather_word |= 24'(data) << (8 * gather_n);
      if (gather_n + 1 >= need) begin
        decode_gathered();
        gather_word = '0;
        gather_n    = 0;
      end else begin
        gather_n++;
      end
    end
    // Row end: close a short row, drop any partial gather
    if (row_pos + 1 >= cur_row_bytes) begin
      if (col < width_cap()) begin
        if (emit_now) emit_rec.last = 1'b1;
        else if (col % 8 != 0) flush_byte(1'b1);
      end
      clear_row();
    end else begin
      row_pos = (row_pos + 1) % 8192;
    end
    if (emit_now) expected_bytes.push_back(emit_rec);
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_DEPTH_SELECT:  cur_depth     = val[DEPTH_W-1:0];
      CFG_FORMAT_565:    cur_565       = val[0];
      CFG_COLOR_ENABLE:  cur_color     = val[0];
      CFG_VISIBLE_WIDTH: cur_width     = val[VIS_W-1:0];
      CFG_ROW_BYTES:     cur_row_bytes = val[ROWB_W-1:0];
      default: ;
    endcase
  endfunction

  // Color levels biased toward the classification thresholds
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return WHITE_LEVEL;
      3:       return WHITE_LEVEL + 8'd1;
      4:       return COLOR_LEVEL;
      5:       return COLOR_LEVEL + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expected byte.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual mono=%h color=%h pos=%0d last=%b",
                 $time, mono_byte, color_byte, byte_position, row_last);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("mono_byte", want.mono, mono_byte);
        check_field("color_byte", want.color, color_byte);
        check_field("byte_position", want.pos, byte_position);
        check_field("row_last", want.last, row_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration tasks
  // ---------------------------------------------------------------------------

  // Offer one item, optionally after an idle burst; hold it until the transfer.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(input cmd_t cmd, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] data);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    command       <= cmd;
    palette_index <= idx;
    red           <= r;
    green         <= g;
    blue          <= b;
    data_byte     <= data;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(cmd, idx, r, g, b, data);
  endtask

  // Unused payload fields carry random values to exercise every input bit.
  task automatic send_pixel(input logic [7:0] data);
    send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    send_item(CMD_PALETTE, idx, r, g, b, 8'($urandom));
  endtask

  // Bitmap byte order is blue, green, red.
  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_pixel(b);
    send_pixel(g);
    send_pixel(r);
  endtask

  // Drop valid, drain every expected byte, then cover the pipeline latency.
  task automatic settle();
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val,
                           input logic more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [DEPTH_W-1:0] depth, input logic f565, input logic wc,
                           input int width, input int rb);
    settle();
    write_reg(CFG_DEPTH_SELECT, CFG_DATA_W'(depth), 1'b1);
    write_reg(CFG_FORMAT_565, CFG_DATA_W'(f565), 1'b1);
    write_reg(CFG_COLOR_ENABLE, CFG_DATA_W'(wc), 1'b1);
    write_reg(CFG_VISIBLE_WIDTH, CFG_DATA_W'(width), 1'b1);
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(rb), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every palette entry so no pixel ever reads an unwritten one.
  task automatic test_load_palette();
    int i;
    for (i = 0; i < PAL_N; i++) load_entry(8'(i), pick_level(), pick_level(), pick_level());
  endtask

  task automatic test_directed();
    // 24 bit: red, green+blue colored, whitish just above threshold, black at threshold
    configure(DEPTH_24, 1'b0, 1'b1, 4, 12);
    send_rgb(8'hFF, 8'h00, 8'h00);
    send_rgb(8'h00, 8'hF1, 8'hF1);
    send_rgb(8'h81, 8'h81, 8'h81);
    send_rgb(8'h80, 8'h81, 8'h81);

    // Zero width converts nothing; zero row bytes ends a row on every byte
    configure(DEPTH_8, 1'b0, 1'b1, 0, 0);
    send_pixel(8'hA5);

    // 16 bit 555: all ones is white, all zeros black
    configure(DEPTH_16, 1'b0, 1'b1, 2, 4);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h00);

    // Depth change mid-gather: three bytes held at 32 bit complete on the next
    // byte at 16 bit; then shrink the row so the next byte ends it (short row).
    configure(DEPTH_32, 1'b0, 1'b1, 8, 16383);
    send_pixel(8'hF8);
    send_pixel(8'h1F);
    send_pixel(8'hFF);
    settle();
    write_reg(CFG_DEPTH_SELECT, CFG_DATA_W'(DEPTH_16), 1'b0);
    send_pixel(8'h3C);
    settle();
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(2), 1'b0);
    send_pixel(8'h77);

    // Spare depth code: four bytes per pixel, alpha ignored
    configure(DEPTH_SPARE, 1'b0, 1'b1, 1, 4);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);

    // Palette entry read right after it is rewritten
    configure(DEPTH_8, 1'b0, 1'b1, 1, 1);
    load_entry(8'h5A, 8'hFF, 8'h00, 8'h00);
    send_pixel(8'h5A);
    load_entry(8'h5A, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h5A);
  endtask

  // Width past the cap: 2048 pixels, 256 output bytes, positions 0 to 255.
  task automatic test_wide_row();
    int i;
    configure(DEPTH_1, 1'b1, 1'b1, 4095, 260);
    for (i = 0; i < 260; i++) send_pixel(pick_level());
  endtask

  // Receiver holds off for a long stretch while bytes keep coming; every
  // 1-bit byte yields a result, so the block fills and stalls its input.
  task automatic test_backpressure();
    int i;
    configure(DEPTH_1, 1'b0, 1'b0, 256, 32);
    hold_req = 1'b1;
    for (i = 0; i < 16; i++) send_pixel(8'($urandom));
  endtask

  // Random configurations, mostly with rows padded the way bitmaps pad them;
  // some rows are cut short or run long, and palette loads are mixed in.
  task automatic test_random_rows(input int n_items);
    int done, depth, width, rb, rows, row_len, r, i;
    done = 0;
    while (done < n_items) begin
      depth = ($urandom_range(0, 15) == 0) ? int'(DEPTH_SPARE) : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0:       width = 0;
        1:       width = $urandom_range(MAX_W - 8, 4095);
        default: width = $urandom_range(1, 48);
      endcase
      rb = ((width * pixel_bits(DEPTH_W'(depth)) + 31) / 32) * 4;
      if (width > 48) rb = $urandom_range(1, 24);
      else if (width == 0 || $urandom_range(0, 4) == 0) rb = $urandom_range(0, rb + 8);
      configure(DEPTH_W'(depth), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                width, rb);
      rows    = $urandom_range(1, 3);
      row_len = (rb == 0) ? 1 : rb;
      // Stop at the item budget, even in the middle of a row
      for (r = 0; r < rows && done < n_items; r++) begin
        for (i = 0; i < row_len && done < n_items; i++) begin
          if ($urandom_range(0, 11) == 0) begin
            load_entry(8'($urandom), pick_level(), pick_level(), pick_level());
            done++;
          end
          send_pixel(pick_level());
          done++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    command       <= CMD_PIXEL;
    palette_index <= '0;
    red           <= '0;
    green         <= '0;
    blue          <= '0;
    data_byte     <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_DEPTH_SELECT;
    cfg_data      <= '0;
    foreach (pal_white[i]) begin
      pal_white[i] = 1'b0;
      pal_color[i] = 1'b0;
    end
    clear_row();
    cur_depth     = RST_DEPTH_SELECT;
    cur_565       = RST_FORMAT_565;
    cur_color     = RST_COLOR_ENABLE;
    cur_width     = RST_VISIBLE_WIDTH;
    cur_row_bytes = RST_ROW_BYTES;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_load_palette();
    test_directed();
    test_wide_row();
    test_backpressure();
    test_random_rows(RANDOM_ITEMS);
    settle();
    quiet = 1'b1;
    test_random_rows(QUIET_ITEMS);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d expected bytes outstanding", expected_bytes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
